>>> rtl/dst_pkg.sv
// Shared types and constants for the dimple surface thickness block.
`timescale 1ns / 1ps
`default_nettype none
package dst_pkg;

  localparam int R2_W   = 64;
  localparam int DIV_W  = 32;
  localparam int LEN_W  = 16;
  localparam int CFG_IW = 3;

  typedef enum logic [1:0] {
    SHAPE_SPHERE  = 2'd0,
    SHAPE_FLAT    = 2'd1,
    SHAPE_CYL     = 2'd2,
    SHAPE_ELLIPSE = 2'd3
  } shape_t;

  localparam logic [CFG_IW-1:0] REG_THICK = 3'd0;
  localparam logic [CFG_IW-1:0] REG_RAD   = 3'd1;
  localparam logic [CFG_IW-1:0] REG_DEP   = 3'd2;
  localparam logic [CFG_IW-1:0] REG_SHAPE = 3'd3;

  typedef struct packed {
    shape_t           mode;
    logic             in_dimple;
    logic             flat;
    logic [LEN_W-1:0] thick;
    logic [LEN_W-1:0] dep;
    logic [LEN_W-1:0] rad;
    logic [31:0]      rr;
    logic [31:0]      dd;
    logic [31:0]      rs;
    logic [31:0]      root1;
    logic [R2_W-1:0]  r2;
  } dst_item_t;

endpackage
`default_nettype wire

>>> rtl/dimple_surface_thickness.sv
// Top level: dimple surface thickness pipeline built from division and square root cells.
// It holds 32 division cells, 32 cells of the wide square root and 16 cells of the narrow
// one. Throughput: one transaction per cycle; every cell advances whenever the output
// register is empty or being taken. Reset (rst, synchronous) clears all valid bits and
// loads the registers with thickness 3000, radius 6000, depth 1000, spherical profile.
`timescale 1ns / 1ps
`default_nettype none
module dimple_surface_thickness
  import dst_pkg::*;
#(
  parameter int COORD_BITS = 18
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_write,
  input  wire logic [CFG_IW-1:0]            cfg_index,
  input  wire logic [LEN_W-1:0]             cfg_data,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic signed [COORD_BITS-1:0] pos_x,
  input  wire logic signed [COORD_BITS-1:0] pos_y,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [LEN_W-1:0]                  local_thickness
);

  localparam int NDIV = DIV_W;
  localparam int NSQ1 = R2_W / 2;
  localparam int NSQ2 = 16;

  logic [LEN_W-1:0] tile_thickness;
  logic [LEN_W-1:0] dimple_radius;
  logic [LEN_W-1:0] dimple_depth;
  shape_t           shape_mode;

  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      tile_thickness <= 16'd3000;
      dimple_radius  <= 16'd6000;
      dimple_depth   <= 16'd1000;
      shape_mode     <= SHAPE_SPHERE;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_THICK: tile_thickness <= cfg_data;
        REG_RAD:   dimple_radius  <= cfg_data;
        REG_DEP:   dimple_depth   <= cfg_data;
        REG_SHAPE: shape_mode     <= shape_t'(cfg_data[1:0]);
        default: begin
        end
      endcase
    end
  end

  // stage 1: magnitudes and squares
  logic [COORD_BITS-1:0]   ax, ay;
  logic [2*COORD_BITS-1:0] sqx, sqy;
  logic [LEN_W-1:0]        rmd;
  always_comb begin
    ax  = pos_x[COORD_BITS-1] ? COORD_BITS'(-pos_x) : COORD_BITS'(pos_x);
    ay  = pos_y[COORD_BITS-1] ? COORD_BITS'(-pos_y) : COORD_BITS'(pos_y);
    sqx = ax * ax;
    sqy = ay * ay;
    rmd = dimple_radius - dimple_depth;
  end

  logic            s1_v;
  dst_item_t       s1_it;
  dst_item_t       s1_it_next;
  logic [R2_W-1:0] s1_ax2, s1_ay2;
  logic [31:0]     s1_rd2;

  always_comb begin
    s1_it_next       = '0;
    s1_it_next.mode  = shape_mode;
    s1_it_next.thick = tile_thickness;
    s1_it_next.dep   = dimple_depth;
    s1_it_next.rad   = dimple_radius;
    s1_it_next.rr    = dimple_radius * dimple_radius;
    s1_it_next.dd    = dimple_depth * dimple_depth;
    s1_it_next.flat  = dimple_radius > dimple_depth;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (adv) begin
      s1_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_it  <= s1_it_next;
      s1_ax2 <= R2_W'(sqx);
      s1_ay2 <= R2_W'(sqy);
      s1_rd2 <= rmd * rmd;
    end
  end

  // stage 2: radius squared and region tests
  logic            s2_v;
  dst_item_t       s2_it;
  dst_item_t       s2_it_next;
  logic [R2_W-1:0] r2;
  assign r2 = s1_ax2 + s1_ay2;

  always_comb begin
    s2_it_next           = s1_it;
    s2_it_next.r2        = r2;
    s2_it_next.in_dimple = (s1_it.dep != '0) && (r2 < R2_W'(s1_it.rr));
    s2_it_next.flat      = s1_it.flat && (r2 < R2_W'(s1_rd2));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (adv) begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_it <= s2_it_next;
    end
  end

  // stage 3: dividend and divisor
  logic            s3_v;
  dst_item_t       s3_it;
  logic [R2_W-1:0] s3_num;
  logic [DIV_W-1:0] s3_den;
  logic [31:0]     rr_less;
  assign rr_less = s2_it.rr - s2_it.r2[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (adv) begin
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_it <= s2_it;
      if (s2_it.mode == SHAPE_ELLIPSE) begin
        s3_num <= s2_it.dd * rr_less;
        s3_den <= s2_it.rr;
      end else begin
        s3_num <= R2_W'(s2_it.rr) + R2_W'(s2_it.dd);
        s3_den <= {15'd0, s2_it.dep, 1'b0};
      end
    end
  end

  // divider chain
  logic             dv_v   [0:NDIV];
  dst_item_t        dv_it  [0:NDIV];
  logic [DIV_W-1:0] dv_rem [0:NDIV];
  logic [DIV_W-1:0] dv_lo  [0:NDIV];
  logic [DIV_W-1:0] dv_den [0:NDIV];

  assign dv_v[0]   = s3_v;
  assign dv_it[0]  = s3_it;
  assign dv_rem[0] = s3_num[R2_W-1:DIV_W];
  assign dv_lo[0]  = s3_num[DIV_W-1:0];
  assign dv_den[0] = s3_den;

  for (genvar i = 0; i < NDIV; i++) begin : g_div
    dst_div_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (adv),
      .v_in    (dv_v[i]),
      .it_in   (dv_it[i]),
      .rem_in  (dv_rem[i]),
      .lo_in   (dv_lo[i]),
      .den_in  (dv_den[i]),
      .v_out   (dv_v[i+1]),
      .it_out  (dv_it[i+1]),
      .rem_out (dv_rem[i+1]),
      .lo_out  (dv_lo[i+1]),
      .den_out (dv_den[i+1])
    );
  end

  // stage M: square of sphere radius
  logic            m_v;
  dst_item_t       m_it;
  dst_item_t       m_it_next;
  logic [R2_W-1:0] m_sq;

  always_comb begin
    m_it_next    = dv_it[NDIV];
    m_it_next.rs = dv_lo[NDIV];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_v <= 1'b0;
    end else if (adv) begin
      m_v <= dv_v[NDIV];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_it <= m_it_next;
      m_sq <= dv_lo[NDIV] * dv_lo[NDIV];
    end
  end

  // stage P: wide radicand
  logic            p_v;
  dst_item_t       p_it;
  logic [R2_W-1:0] p_rad;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_v <= 1'b0;
    end else if (adv) begin
      p_v <= m_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_it <= m_it;
      unique case (m_it.mode)
        SHAPE_SPHERE:  p_rad <= m_sq - m_it.r2;
        SHAPE_FLAT:    p_rad <= m_it.r2;
        SHAPE_CYL:     p_rad <= m_it.r2;
        SHAPE_ELLIPSE: p_rad <= R2_W'(m_it.rs);
      endcase
    end
  end

  // wide square root chain
  logic            q1_v    [0:NSQ1];
  dst_item_t       q1_it   [0:NSQ1];
  logic [R2_W-1:0] q1_rad  [0:NSQ1];
  logic [NSQ1-1:0] q1_root [0:NSQ1];
  logic [NSQ1+1:0] q1_rem  [0:NSQ1];

  assign q1_v[0]    = p_v;
  assign q1_it[0]   = p_it;
  assign q1_rad[0]  = p_rad;
  assign q1_root[0] = '0;
  assign q1_rem[0]  = '0;

  for (genvar i = 0; i < NSQ1; i++) begin : g_sq1
    dst_sqrt_cell #(.ROOT_W(NSQ1)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (adv),
      .v_in     (q1_v[i]),
      .it_in    (q1_it[i]),
      .rad_in   (q1_rad[i]),
      .root_in  (q1_root[i]),
      .rem_in   (q1_rem[i]),
      .v_out    (q1_v[i+1]),
      .it_out   (q1_it[i+1]),
      .rad_out  (q1_rad[i+1]),
      .root_out (q1_root[i+1]),
      .rem_out  (q1_rem[i+1])
    );
  end

  // stage F: torus offset squared
  logic        f_v;
  dst_item_t   f_it;
  dst_item_t   f_it_next;
  logic [31:0] f_dsq;
  logic [15:0] dif;
  assign dif = q1_root[NSQ1][15:0] + q1_it[NSQ1].dep - q1_it[NSQ1].rad;

  always_comb begin
    f_it_next       = q1_it[NSQ1];
    f_it_next.root1 = q1_root[NSQ1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_v <= 1'b0;
    end else if (adv) begin
      f_v <= q1_v[NSQ1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_it  <= f_it_next;
      f_dsq <= dif * dif;
    end
  end

  // stage G: narrow radicand
  logic        g_v;
  dst_item_t   g_it;
  logic [31:0] g_rad;

  always_ff @(posedge clk) begin
    if (rst) begin
      g_v <= 1'b0;
    end else if (adv) begin
      g_v <= f_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g_it  <= f_it;
      g_rad <= f_it.dd - f_dsq;
    end
  end

  // narrow square root chain
  logic            q2_v    [0:NSQ2];
  dst_item_t       q2_it   [0:NSQ2];
  logic [31:0]     q2_rad  [0:NSQ2];
  logic [NSQ2-1:0] q2_root [0:NSQ2];
  logic [NSQ2+1:0] q2_rem  [0:NSQ2];

  assign q2_v[0]    = g_v;
  assign q2_it[0]   = g_it;
  assign q2_rad[0]  = g_rad;
  assign q2_root[0] = '0;
  assign q2_rem[0]  = '0;

  for (genvar i = 0; i < NSQ2; i++) begin : g_sq2
    dst_sqrt_cell #(.ROOT_W(NSQ2)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (adv),
      .v_in     (q2_v[i]),
      .it_in    (q2_it[i]),
      .rad_in   (q2_rad[i]),
      .root_in  (q2_root[i]),
      .rem_in   (q2_rem[i]),
      .v_out    (q2_v[i+1]),
      .it_out   (q2_it[i+1]),
      .rad_out  (q2_rad[i+1]),
      .root_out (q2_root[i+1]),
      .rem_out  (q2_rem[i+1])
    );
  end

  // output stage: depth by profile, subtract, saturate
  dst_item_t        z_it;
  logic [32:0]      sum;
  logic [32:0]      depth;
  logic [LEN_W-1:0] res;

  always_comb begin
    z_it = q2_it[NSQ2];
    sum  = {1'b0, z_it.root1} + 33'(z_it.dep);
    unique case (z_it.mode)
      SHAPE_SPHERE:  depth = (sum <= 33'(z_it.rs)) ? '0 : sum - 33'(z_it.rs);
      SHAPE_FLAT:    depth = z_it.flat ? 33'(z_it.dep) : 33'(q2_root[NSQ2]);
      SHAPE_CYL:     depth = 33'(z_it.dep);
      SHAPE_ELLIPSE: depth = 33'(z_it.root1);
    endcase
    if (!z_it.in_dimple) begin
      res = z_it.thick;
    end else if (depth >= 33'(z_it.thick)) begin
      res = '0;
    end else begin
      res = z_it.thick - depth[LEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= q2_v[NSQ2];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      local_thickness <= res;
    end
  end

endmodule
`default_nettype wire

>>> rtl/dst_div_cell.sv
// One restoring division step: shifts a dividend bit in and forms one quotient bit.
`timescale 1ns / 1ps
`default_nettype none
module dst_div_cell
  import dst_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic             v_in,
  input  wire dst_item_t        it_in,
  input  wire logic [DIV_W-1:0] rem_in,
  input  wire logic [DIV_W-1:0] lo_in,
  input  wire logic [DIV_W-1:0] den_in,
  output logic                  v_out,
  output dst_item_t             it_out,
  output logic [DIV_W-1:0]      rem_out,
  output logic [DIV_W-1:0]      lo_out,
  output logic [DIV_W-1:0]      den_out
);

  logic [DIV_W:0]   t;
  logic [DIV_W:0]   diff;
  logic             ge;

  always_comb begin
    t    = {rem_in, lo_in[DIV_W-1]};
    diff = t - {1'b0, den_in};
    ge   = (t >= {1'b0, den_in});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (en) begin
      v_out <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it_out  <= it_in;
      rem_out <= ge ? diff[DIV_W-1:0] : t[DIV_W-1:0];
      lo_out  <= {lo_in[DIV_W-2:0], ge};
      den_out <= den_in;
    end
  end

endmodule
`default_nettype wire

>>> rtl/dst_sqrt_cell.sv
// One digit-by-digit square root step: takes two radicand bits, forms one root bit.
`timescale 1ns / 1ps
`default_nettype none
module dst_sqrt_cell
  import dst_pkg::*;
#(
  parameter int ROOT_W = 32
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                en,
  input  wire logic                v_in,
  input  wire dst_item_t           it_in,
  input  wire logic [2*ROOT_W-1:0] rad_in,
  input  wire logic [ROOT_W-1:0]   root_in,
  input  wire logic [ROOT_W+1:0]   rem_in,
  output logic                     v_out,
  output dst_item_t                it_out,
  output logic [2*ROOT_W-1:0]      rad_out,
  output logic [ROOT_W-1:0]        root_out,
  output logic [ROOT_W+1:0]        rem_out
);

  logic [ROOT_W+3:0] t;
  logic [ROOT_W+3:0] trial;
  logic [ROOT_W+3:0] diff;
  logic              ge;

  always_comb begin
    t     = {rem_in, rad_in[2*ROOT_W-1 -: 2]};
    trial = {2'b00, root_in, 2'b01};
    diff  = t - trial;
    ge    = (t >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (en) begin
      v_out <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it_out   <= it_in;
      rad_out  <= {rad_in[2*ROOT_W-3:0], 2'b00};
      root_out <= {root_in[ROOT_W-2:0], ge};
      rem_out  <= ge ? diff[ROOT_W+1:0] : t[ROOT_W+1:0];
    end
  end

endmodule
`default_nettype wire

>>> rtl/dst_checker.sv
// Port-level checker for the dimple surface thickness block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module dst_checker
  import dst_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             in_valid,
  input wire logic             in_stall,
  input wire logic             out_valid,
  input wire logic             out_stall,
  input wire logic [LEN_W-1:0] local_thickness
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(local_thickness))
    else $error("stalled result changed");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow output stall");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    in_valid && !out_valid |-> !in_stall)
    else $error("input stalled while no result is waiting");

endmodule

bind dimple_surface_thickness dst_checker u_dst_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .local_thickness (local_thickness)
);
`default_nettype wire
